>>> rtl/core/cir_pkg.sv
`timescale 1ns / 1ps

package cir_pkg;

  localparam int unsigned VelW = 32;
  localparam int unsigned NrmW = 16;
  localparam int unsigned ImW = 32;
  localparam int unsigned ResW = 16;
  localparam int unsigned CntW = 4;
  localparam int unsigned MaxContactsDef = 15;

  localparam int unsigned DiffW = VelW + 1;
  localparam int unsigned ProdW = DiffW + NrmW;
  localparam int unsigned DotW = ProdW + 1;
  localparam int unsigned MW = 35;
  localparam int unsigned EfW = ResW + 1;
  localparam int unsigned SW = 36;
  localparam int unsigned FracR = 24;
  localparam int unsigned RW = FracR + 1;
  localparam int unsigned KW = 36;
  localparam int unsigned DigW = 4;
  localparam int unsigned CdivStages = KW / DigW;
  localparam int unsigned MdivStages = RW;
  localparam int unsigned MagW = 38;
  localparam int unsigned SumW = MagW + 2;

  typedef enum logic [1:0] {
    OcApplied  = 2'd0,
    OcStatic   = 2'd1,
    OcSeparate = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [VelW-1:0] vax;
    logic [VelW-1:0] vay;
    logic [VelW-1:0] vbx;
    logic [VelW-1:0] vby;
  } vel_t;

  typedef struct packed {
    vel_t            vel;
    logic [NrmW-1:0] nx;
    logic [NrmW-1:0] ny;
    logic [ImW-1:0]  ima;
    logic [ImW-1:0]  imb;
    logic [ResW-1:0] ea;
    logic [ResW-1:0] eb;
    logic [CntW-1:0] cnt;
  } in_t;

  typedef struct packed {
    vel_t            vel;
    logic [NrmW-1:0] nx;
    logic [NrmW-1:0] ny;
    outcome_e        oc;
  } pass_t;

  typedef struct packed {
    pass_t           p;
    logic [CntW-1:0] cnt;
    logic [SW-1:0]   s;
  } imp_t;

  typedef struct packed {
    imp_t           i;
    logic [ImW-1:0] ima;
    logic [ImW:0]   ims;
  } front_t;

  typedef struct packed {
    imp_t          i;
    logic [RW-1:0] ra;
    logic          rnz;
  } share_t;

  typedef struct packed {
    pass_t           p;
    logic [CntW-1:0] c;
    logic [KW-1:0]   xa;
    logic [KW-1:0]   xb;
  } cdin_t;

  typedef struct packed {
    pass_t         p;
    logic [KW-1:0] ka;
    logic [KW-1:0] kb;
  } kk_t;

  typedef struct packed {
    vel_t     vel;
    outcome_e oc;
  } res_t;

endpackage

>>> rtl/core/cir_front.sv
`timescale 1ns / 1ps

module cir_front import cir_pkg::*; #(
  parameter int unsigned MaxContacts = MaxContactsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  in_t    in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output front_t out_o
);

  localparam int unsigned NSt = 5;

  logic [NSt-1:0] v_q;
  logic [NSt-1:0] en;

  pass_t p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DiffW-1:0] dx1_q, dy1_q;
  logic signed [ProdW-1:0] px2_q, py2_q;
  logic signed [DotW-1:0] d3_q;
  logic [ImW-1:0] ima1_q, ima2_q, ima3_q, ima4_q, ima5_q;
  logic [ImW:0] ims1_q, ims2_q, ims3_q, ims4_q, ims5_q;
  logic [ResW-1:0] em1_q, em2_q, em3_q;
  logic [EfW-1:0] ef4_q;
  logic [CntW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q;
  logic [MW-1:0] m4_q;
  logic [SW-1:0] s5_q;

  logic [CntW-1:0] cnt_sat;
  logic [ResW-1:0] emax;
  logic [DotW-1:0] mneg, mrnd;
  logic [MW+EfW-1:0] sprod;
  outcome_e oc3;

  always_comb begin
    en[NSt-1] = !v_q[NSt-1] || out_ready_i;
    for (int k = NSt-2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];
  assign out_valid_o = v_q[NSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSt; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_comb begin
    cnt_sat = in_i.cnt;
    if (32'(in_i.cnt) > MaxContacts) cnt_sat = CntW'(MaxContacts);
    emax = (in_i.ea > in_i.eb) ? in_i.ea : in_i.eb;
    if (ims3_q == '0) begin
      oc3 = OcStatic;
    end else if (d3_q > 0) begin
      oc3 = OcSeparate;
    end else begin
      oc3 = OcApplied;
    end
    mneg = DotW'(-d3_q);
    mrnd = mneg + DotW'(8192);
    sprod = (MW+EfW)'(m4_q) * (MW+EfW)'(ef4_q) + (MW+EfW)'(16384);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_q.vel <= in_i.vel;
      p1_q.nx <= in_i.nx;
      p1_q.ny <= in_i.ny;
      p1_q.oc <= OcApplied;
      dx1_q <= $signed({in_i.vel.vbx[VelW-1], in_i.vel.vbx})
             - $signed({in_i.vel.vax[VelW-1], in_i.vel.vax});
      dy1_q <= $signed({in_i.vel.vby[VelW-1], in_i.vel.vby})
             - $signed({in_i.vel.vay[VelW-1], in_i.vel.vay});
      ima1_q <= in_i.ima;
      ims1_q <= {1'b0, in_i.ima} + {1'b0, in_i.imb};
      em1_q <= emax;
      c1_q <= cnt_sat;
    end
    if (en[1]) begin
      p2_q <= p1_q;
      px2_q <= dx1_q * $signed(p1_q.nx);
      py2_q <= dy1_q * $signed(p1_q.ny);
      ima2_q <= ima1_q;
      ims2_q <= ims1_q;
      em2_q <= em1_q;
      c2_q <= c1_q;
    end
    if (en[2]) begin
      p3_q <= p2_q;
      d3_q <= DotW'(px2_q) + DotW'(py2_q);
      ima3_q <= ima2_q;
      ims3_q <= ims2_q;
      em3_q <= em2_q;
      c3_q <= c2_q;
    end
    if (en[3]) begin
      p4_q.vel <= p3_q.vel;
      p4_q.nx <= p3_q.nx;
      p4_q.ny <= p3_q.ny;
      p4_q.oc <= oc3;
      m4_q <= mrnd[14 +: MW];
      ef4_q <= EfW'(32768) + EfW'(em3_q);
      ima4_q <= ima3_q;
      ims4_q <= ims3_q;
      c4_q <= c3_q;
    end
    if (en[4]) begin
      p5_q <= p4_q;
      s5_q <= sprod[15 +: SW];
      ima5_q <= ima4_q;
      ims5_q <= ims4_q;
      c5_q <= c4_q;
    end
  end

  always_comb begin
    out_o.i.p = p5_q;
    out_o.i.cnt = c5_q;
    out_o.i.s = s5_q;
    out_o.ima = ima5_q;
    out_o.ims = ims5_q;
  end

endmodule

>>> rtl/core/cir_mdiv.sv
`timescale 1ns / 1ps

module cir_mdiv import cir_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  front_t in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output share_t out_o
);

  localparam int unsigned NSt = MdivStages;

  logic [NSt-1:0] v_q;
  logic [NSt-1:0] en;

  imp_t          side_q [NSt];
  logic [ImW:0]  ims_q  [NSt];
  logic [ImW:0]  rem_q  [NSt];
  logic [RW-1:0] quo_q  [NSt];
  logic [ImW:0]  rem_d  [NSt];
  logic [RW-1:0] quo_d  [NSt];

  logic          ge0;
  logic [ImW+1:0] t;
  logic [ImW+1:0] tsub;

  always_comb begin
    en[NSt-1] = !v_q[NSt-1] || out_ready_i;
    for (int k = NSt-2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];
  assign out_valid_o = v_q[NSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSt; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // whole-share bit first, then one quotient bit per stage
  always_comb begin
    t = '0;
    tsub = '0;
    ge0 = ({1'b0, in_i.ima} >= in_i.ims);
    rem_d[0] = ge0 ? ({1'b0, in_i.ima} - in_i.ims) : {1'b0, in_i.ima};
    quo_d[0] = '0;
    quo_d[0][RW-1] = ge0;
    for (int k = 1; k < NSt; k++) begin
      t = {rem_q[k-1], 1'b0};
      tsub = t - {1'b0, ims_q[k-1]};
      quo_d[k] = quo_q[k-1];
      if (t >= {1'b0, ims_q[k-1]}) begin
        quo_d[k][RW-1-k] = 1'b1;
        rem_d[k] = tsub[ImW:0];
      end else begin
        rem_d[k] = t[ImW:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= in_i.i;
      ims_q[0] <= in_i.ims;
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
    end
    for (int k = 1; k < NSt; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
        ims_q[k] <= ims_q[k-1];
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  always_comb begin
    out_o.i = side_q[NSt-1];
    out_o.ra = quo_q[NSt-1];
    out_o.rnz = (rem_q[NSt-1] != '0);
  end

endmodule

>>> rtl/core/cir_scale.sv
`timescale 1ns / 1ps

module cir_scale import cir_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  share_t in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output cdin_t  out_o
);

  localparam int unsigned PW = SW + RW;

  logic [1:0] v_q;
  logic [1:0] en;

  imp_t          i1_q;
  logic [PW-1:0] pa1_q, pb1_q;
  cdin_t         o2_q;

  logic [RW-1:0] rb;
  logic [PW-1:0] pa_r, pb_r;
  logic [KW-1:0] half;

  assign en[1] = !v_q[1] || out_ready_i;
  assign en[0] = !v_q[0] || en[1];
  assign in_ready_o = en[0];
  assign out_valid_o = v_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  // shares sum to one, less one lsb when the division was inexact
  always_comb begin
    rb = RW'(1 << FracR) - in_i.ra - RW'(in_i.rnz);
    pa_r = pa1_q + PW'(1 << (FracR - 1));
    pb_r = pb1_q + PW'(1 << (FracR - 1));
    half = (i1_q.cnt > CntW'(1)) ? KW'(i1_q.cnt >> 1) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      i1_q <= in_i.i;
      pa1_q <= PW'(in_i.i.s) * PW'(in_i.ra);
      pb1_q <= PW'(in_i.i.s) * PW'(rb);
    end
    if (en[1]) begin
      o2_q.p <= i1_q.p;
      o2_q.c <= (i1_q.cnt > CntW'(1)) ? i1_q.cnt : CntW'(1);
      o2_q.xa <= pa_r[FracR +: KW] + half;
      o2_q.xb <= pb_r[FracR +: KW] + half;
    end
  end

  assign out_o = o2_q;

endmodule

>>> rtl/core/cir_cdiv.sv
`timescale 1ns / 1ps

module cir_cdiv import cir_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  cdin_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output kk_t   out_o
);

  localparam int unsigned NSt = CdivStages;

  logic [NSt-1:0] v_q;
  logic [NSt-1:0] en;

  pass_t           p_q  [NSt];
  logic [CntW-1:0] c_q  [NSt];
  logic [KW-1:0]   xa_q [NSt];
  logic [KW-1:0]   xb_q [NSt];
  logic [CntW-1:0] ra_q [NSt];
  logic [CntW-1:0] rb_q [NSt];
  logic [KW-1:0]   xa_d [NSt];
  logic [KW-1:0]   xb_d [NSt];
  logic [CntW-1:0] ra_d [NSt];
  logic [CntW-1:0] rb_d [NSt];

  logic [2*DigW-1:0] sa, sb;

  function automatic logic [2*DigW-1:0] div_digit(logic [CntW-1:0] c, logic [CntW-1:0] r,
                                                 logic [DigW-1:0] dig);
    logic [CntW:0]   t;
    logic [CntW-1:0] rr;
    logic [DigW-1:0] q;
    rr = r;
    q = '0;
    for (int j = DigW-1; j >= 0; j--) begin
      t = {rr, dig[j]};
      if (t >= {1'b0, c}) begin
        q[j] = 1'b1;
        t = t - {1'b0, c};
      end
      rr = t[CntW-1:0];
    end
    return {q, rr};
  endfunction

  always_comb begin
    en[NSt-1] = !v_q[NSt-1] || out_ready_i;
    for (int k = NSt-2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];
  assign out_valid_o = v_q[NSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSt; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // quotient digits overwrite the dividend digits they came from
  always_comb begin
    xa_d[0] = in_i.xa;
    xb_d[0] = in_i.xb;
    sa = div_digit(in_i.c, '0, in_i.xa[KW-1 -: DigW]);
    sb = div_digit(in_i.c, '0, in_i.xb[KW-1 -: DigW]);
    xa_d[0][KW-1 -: DigW] = sa[2*DigW-1 -: DigW];
    xb_d[0][KW-1 -: DigW] = sb[2*DigW-1 -: DigW];
    ra_d[0] = sa[CntW-1:0];
    rb_d[0] = sb[CntW-1:0];
    for (int k = 1; k < NSt; k++) begin
      xa_d[k] = xa_q[k-1];
      xb_d[k] = xb_q[k-1];
      sa = div_digit(c_q[k-1], ra_q[k-1], xa_q[k-1][KW-1-DigW*k -: DigW]);
      sb = div_digit(c_q[k-1], rb_q[k-1], xb_q[k-1][KW-1-DigW*k -: DigW]);
      xa_d[k][KW-1-DigW*k -: DigW] = sa[2*DigW-1 -: DigW];
      xb_d[k][KW-1-DigW*k -: DigW] = sb[2*DigW-1 -: DigW];
      ra_d[k] = sa[CntW-1:0];
      rb_d[k] = sb[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_q[0] <= in_i.p;
      c_q[0] <= in_i.c;
      xa_q[0] <= xa_d[0];
      xb_q[0] <= xb_d[0];
      ra_q[0] <= ra_d[0];
      rb_q[0] <= rb_d[0];
    end
    for (int k = 1; k < NSt; k++) begin
      if (en[k]) begin
        p_q[k] <= p_q[k-1];
        c_q[k] <= c_q[k-1];
        xa_q[k] <= xa_d[k];
        xb_q[k] <= xb_d[k];
        ra_q[k] <= ra_d[k];
        rb_q[k] <= rb_d[k];
      end
    end
  end

  always_comb begin
    out_o.p = p_q[NSt-1];
    out_o.ka = xa_q[NSt-1];
    out_o.kb = xb_q[NSt-1];
  end

endmodule

>>> rtl/core/cir_apply.sv
`timescale 1ns / 1ps

module cir_apply import cir_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  kk_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  localparam int unsigned PW = KW + NrmW;

  logic [1:0] v_q;
  logic [1:0] en;

  pass_t         p1_q;
  logic [PW-1:0] pax_q, pay_q, pbx_q, pby_q;
  res_t          o2_q;

  logic [NrmW-1:0] anx, any;
  logic [PW-1:0]   rax, ray, rbx, rby;
  logic            sx, sy;

  function automatic logic [VelW-1:0] sat_add(logic [VelW-1:0] v, logic [MagW-1:0] mag,
                                              logic sub);
    logic signed [SumW-1:0] ve, me, sum;
    ve = SumW'($signed(v));
    me = $signed({2'b00, mag});
    sum = sub ? (ve - me) : (ve + me);
    if (sum > $signed(SumW'(32'h7fff_ffff))) begin
      return 32'h7fff_ffff;
    end else if (sum < -$signed(SumW'(33'h0_8000_0000))) begin
      return 32'h8000_0000;
    end
    return sum[VelW-1:0];
  endfunction

  assign en[1] = !v_q[1] || out_ready_i;
  assign en[0] = !v_q[0] || en[1];
  assign in_ready_o = en[0];
  assign out_valid_o = v_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  always_comb begin
    anx = in_i.p.nx[NrmW-1] ? (NrmW'(0) - in_i.p.nx) : in_i.p.nx;
    any = in_i.p.ny[NrmW-1] ? (NrmW'(0) - in_i.p.ny) : in_i.p.ny;
    rax = pax_q + PW'(8192);
    ray = pay_q + PW'(8192);
    rbx = pbx_q + PW'(8192);
    rby = pby_q + PW'(8192);
    sx = p1_q.nx[NrmW-1];
    sy = p1_q.ny[NrmW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_q <= in_i.p;
      pax_q <= PW'(in_i.ka) * PW'(anx);
      pay_q <= PW'(in_i.ka) * PW'(any);
      pbx_q <= PW'(in_i.kb) * PW'(anx);
      pby_q <= PW'(in_i.kb) * PW'(any);
    end
    if (en[1]) begin
      o2_q.oc <= p1_q.oc;
      if (p1_q.oc == OcApplied) begin
        o2_q.vel.vax <= sat_add(p1_q.vel.vax, rax[14 +: MagW], !sx);
        o2_q.vel.vay <= sat_add(p1_q.vel.vay, ray[14 +: MagW], !sy);
        o2_q.vel.vbx <= sat_add(p1_q.vel.vbx, rbx[14 +: MagW], sx);
        o2_q.vel.vby <= sat_add(p1_q.vel.vby, rby[14 +: MagW], sy);
      end else begin
        o2_q.vel <= p1_q.vel;
      end
    end
  end

  assign out_o = o2_q;

endmodule

>>> rtl/core/contact_impulse_resolve.sv
// beats pass in order through front, mass-share divider, scale, count divider and apply
// throughput: one contact per cycle when not stalled, set by the fully pipelined
//   mass-share divider (one quotient bit per stage) and count divider (four bits per stage)
// each stage holds its beat while the next one is full, so stalls lose nothing
// reset: asynchronous active-low, clears all valid bits; data registers are not reset
`timescale 1ns / 1ps

module contact_impulse_resolve import cir_pkg::*; #(
  parameter int unsigned MaxContacts = MaxContactsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vel_a_x, vel_a_y, vel_b_x, vel_b_y, normal_x, normal_y, inv_mass_a,
  // inv_mass_b, restitution_a, restitution_b, contact_count, zero pad
  input  logic [263:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
  output logic [127:0] m_axis_tdata,
  // outcome
  output logic [1:0]   m_axis_tuser
);

  in_t    in_s;
  front_t front_s;
  share_t share_s;
  cdin_t  cdin_s;
  kk_t    kk_s;
  res_t   res_s;

  logic front_v, front_r, share_v, share_r, cdin_v, cdin_r, kk_v, kk_r;

  always_comb begin
    in_s.vel.vax = s_axis_tdata[31:0];
    in_s.vel.vay = s_axis_tdata[63:32];
    in_s.vel.vbx = s_axis_tdata[95:64];
    in_s.vel.vby = s_axis_tdata[127:96];
    in_s.nx = s_axis_tdata[143:128];
    in_s.ny = s_axis_tdata[159:144];
    in_s.ima = s_axis_tdata[191:160];
    in_s.imb = s_axis_tdata[223:192];
    in_s.ea = s_axis_tdata[239:224];
    in_s.eb = s_axis_tdata[255:240];
    in_s.cnt = s_axis_tdata[259:256];
  end

  cir_front #(
    .MaxContacts(MaxContacts)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_i       (in_s),
    .out_valid_o(front_v),
    .out_ready_i(front_r),
    .out_o      (front_s)
  );

  cir_mdiv u_mdiv (
    .clk_i,
    .rst_ni,
    .in_valid_i (front_v),
    .in_ready_o (front_r),
    .in_i       (front_s),
    .out_valid_o(share_v),
    .out_ready_i(share_r),
    .out_o      (share_s)
  );

  cir_scale u_scale (
    .clk_i,
    .rst_ni,
    .in_valid_i (share_v),
    .in_ready_o (share_r),
    .in_i       (share_s),
    .out_valid_o(cdin_v),
    .out_ready_i(cdin_r),
    .out_o      (cdin_s)
  );

  cir_cdiv u_cdiv (
    .clk_i,
    .rst_ni,
    .in_valid_i (cdin_v),
    .in_ready_o (cdin_r),
    .in_i       (cdin_s),
    .out_valid_o(kk_v),
    .out_ready_i(kk_r),
    .out_o      (kk_s)
  );

  cir_apply u_apply (
    .clk_i,
    .rst_ni,
    .in_valid_i (kk_v),
    .in_ready_o (kk_r),
    .in_i       (kk_s),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (res_s)
  );

  assign m_axis_tdata = {res_s.vel.vby, res_s.vel.vbx, res_s.vel.vay, res_s.vel.vax};
  assign m_axis_tuser = res_s.oc;

  a_share_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    share_v && share_s.i.p.oc != OcStatic |-> share_s.ra <= RW'(1 << FracR))
    else $error("mass share above one");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

endmodule
